// ===== src/nsc_pkg.sv =====
// Shared types, character codes and status codes for the NMEA checksum checker.
`default_nettype none

package nsc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 8;

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_MISMATCH = 2'd1;
  localparam status_t ST_TOO_LONG = 2'd2;
  localparam status_t ST_NO_STAR  = 2'd3;

  // Per-sentence tracking state.
  typedef struct packed {
    logic               open_flag;
    logic               star_seen;
    logic [1:0]         digit_count;
    logic [COUNT_W-1:0] byte_count;
    logic [BYTE_W-1:0]  running_xor;
    logic [BYTE_W-1:0]  hex_value;
  } sent_state_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] computed_sum;
    logic [BYTE_W-1:0] received_sum;
  } result_t;

  // Upper-case hex digit; anything else decodes as zero.
  function automatic logic [3:0] hex_digit(input logic [BYTE_W-1:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = 4'(c - 8'h41 + 8'd10);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== src/nsc_ifs.sv =====
// Valid/ready channel interfaces for the received bytes and the check results.
`default_nettype none

interface nsc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] computed_sum;
  logic [7:0] received_sum;

  modport source (output valid, output status, output computed_sum,
                  output received_sum, input ready);
  modport sink   (input valid, input status, input computed_sum,
                  input received_sum, output ready);
endinterface

`default_nettype wire

// ===== src/nsc_core.sv =====
// Per-byte sentence tracking: next state, close detection and status decode.
`default_nettype none

module nsc_core #(
  parameter int unsigned MAX_LEN = 255
) (
  input  wire logic [7:0]          rx_byte,
  input  wire nsc_pkg::sent_state_t state,
  output nsc_pkg::sent_state_t     state_next,
  output logic                     emit,
  output nsc_pkg::result_t         result
);
  import nsc_pkg::*;

  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_LEN);

  sent_state_t cleared;
  logic        at_limit;

  assign at_limit = (state.byte_count >= MaxCount);

  always_comb begin
    cleared           = '0;
    cleared.open_flag = state.open_flag;
  end

  // Result of closing the current sentence.
  always_comb begin
    result.computed_sum = state.running_xor;
    result.received_sum = '0;
    if (state.star_seen) begin
      result.received_sum = state.hex_value;
      result.status = (state.hex_value == state.running_xor) ? ST_OK : ST_MISMATCH;
    end else if (at_limit) begin
      result.status = ST_TOO_LONG;
    end else begin
      result.status = ST_NO_STAR;
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    if (rx_byte == CH_DOLLAR) begin
      emit                 = state.open_flag;
      state_next           = cleared;
      state_next.open_flag = 1'b1;
    end else if (!state.open_flag) begin
      state_next = state;
    end else if (rx_byte == CH_LF) begin
      emit                 = 1'b1;
      state_next           = cleared;
      state_next.open_flag = 1'b0;
    end else if (!state.star_seen) begin
      // Once the count saturates without a star, the rest of the body is dropped.
      if (!at_limit) begin
        if (rx_byte == CH_STAR) begin
          state_next.star_seen = 1'b1;
        end else begin
          state_next.running_xor = state.running_xor ^ rx_byte;
          state_next.byte_count  = state.byte_count + COUNT_W'(1);
        end
      end
    end else begin
      case (state.digit_count)
        2'd0: begin
          state_next.hex_value   = {hex_digit(rx_byte), 4'd0};
          state_next.digit_count = 2'd1;
        end
        2'd1: begin
          state_next.hex_value   = {state.hex_value[7:4], hex_digit(rx_byte)};
          state_next.digit_count = 2'd2;
        end
        default: begin
          state_next.digit_count = state.digit_count;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/nmea_sentence_checksum_checker_unit.sv =====
// NMEA 0183 sentence checksum checker: byte stream in, one status per sentence out.
//
// Usage:
//   rx  : one received character per request (valid/ready). A '$' opens a
//         sentence; bytes up to '*' are XORed; the two following upper-case
//         hex characters are the received checksum. A line feed, or a new '$'
//         while a sentence is open, closes the sentence.
//   res : one request per closed sentence with status (0 ok, 1 mismatch,
//         2 no '*' within MAX_LEN bytes, 3 no '*' before close), the computed
//         XOR and the received checksum.
//   Throughput is one byte per cycle, set by the sentence state update, except while
//   a closing byte waits on a stalled res. An accepted byte is held in the input
//   register and evaluated there; a closing byte's result loads the result register.
//   Reset (rst, synchronous) closes any open sentence without a result and
//   empties the input and result registers.
//   When res is stalled the result register holds; bytes that close no
//   sentence keep flowing, and a closing byte waits in the input register,
//   which then drops rx.ready until the result is taken.
`default_nettype none

module nmea_sentence_checksum_checker_unit #(
  parameter int unsigned MAX_LEN = 255
) (
  input wire logic  clk,
  input wire logic  rst,
  nsc_rx_if.sink    rx,
  nsc_res_if.source res
);
  import nsc_pkg::*;

  // Input register.
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;

  // Sentence state.
  sent_state_t state;
  sent_state_t state_next;

  // Result register.
  logic    out_valid;
  result_t out_data;

  logic    emit;
  result_t result;
  logic    out_free;
  logic    fire;

  nsc_core #(
    .MAX_LEN(MAX_LEN)
  ) u_core (
    .rx_byte    (in_byte),
    .state      (state),
    .state_next (state_next),
    .emit       (emit),
    .result     (result)
  );

  assign out_free = !out_valid || res.ready;
  assign fire     = in_valid && (!emit || out_free);
  assign rx.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_data <= result;
    end
  end

  assign res.valid        = out_valid;
  assign res.status       = out_data.status;
  assign res.computed_sum = out_data.computed_sum;
  assign res.received_sum = out_data.received_sum;

  a_close_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire && emit |=> out_valid)
    else $error("closed sentence did not load the result register");

  a_ok_means_equal: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_OK |-> out_data.computed_sum == out_data.received_sum)
    else $error("ok status with differing sums");

  a_no_star_zero_rcv: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_TOO_LONG || out_data.status == ST_NO_STAR)
    |-> out_data.received_sum == '0)
    else $error("received sum nonzero without a star");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    state.byte_count <= COUNT_W'(MAX_LEN))
    else $error("byte count above limit");

  a_closed_is_clear: assert property (@(posedge clk) disable iff (rst)
    !state.open_flag |-> state.byte_count == '0 && !state.star_seen && state.running_xor == '0)
    else $error("sentence state left over with no sentence open");

endmodule

`default_nettype wire
